@@ hw/rtl/fba_pkg.sv @@
package fba_pkg;

    localparam int DISK_BLOCKS_DEF = 64;
    localparam int MAX_FILES_DEF   = 26;

    // Widths of the item fields and of the disk size register.
    localparam int OP_W   = 2;
    localparam int ID_W   = 5;
    localparam int CNT_W  = 7;
    localparam int ST_W   = 3;
    localparam int BLK_W  = 6;

    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [ST_W-1:0] STAT_OK      = 3'd0;
    localparam logic [ST_W-1:0] STAT_UNDEF   = 3'd1;
    localparam logic [ST_W-1:0] STAT_NOSPACE = 3'd2;
    localparam logic [ST_W-1:0] STAT_NOFILE  = 3'd3;
    localparam logic [ST_W-1:0] STAT_EXISTS  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [ID_W-1:0]  file_id;
        logic [CNT_W-1:0] block_count;
    } in_item_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [BLK_W-1:0] block_index;
        logic             has_block;
        logic             last;
    } out_item_t;

    typedef enum logic [1:0] {
        FILE_ABSENT,
        FILE_EMPTY,
        FILE_PRESENT
    } file_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CREATE,
        S_RD_REQ,
        S_RD_CHK,
        S_DEL_REQ,
        S_DEL_CHK,
        S_DEL_END,
        S_RESULT
    } state_t;

endpackage

@@ hw/rtl/fba_owner_ram.sv @@
module fba_owner_ram
    import fba_pkg::*;
#(
    parameter int DEPTH = DISK_BLOCKS_DEF,
    parameter int AW    = 6,
    parameter int DW    = ID_W
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/fat_block_allocator_unit.sv @@
// Linked-block file allocator over a disk of up to DISK_BLOCKS blocks.
// Input channel (in_valid/in_ready/in_item) takes one command item at a time:
// create, read chain or delete. Output channel (out_valid/out_ready/out_item)
// returns result items; a read of a file with blocks returns one item per block, the
// final one flagged by last. Every other command or read returns exactly one item.
// cfg_we/cfg_data set the disk size and empty all tables at once; sizes above
// DISK_BLOCKS are taken as DISK_BLOCKS. Write it only while the block is idle.
// Create walks the valid bits block by block; read and delete scan the owner
// memory entry by entry, each entry taking a request state and a check state
// (registered read, then check and, for delete, write back).
// Only one command is in work at a time; in_ready is high only when idle.
// Results sit in an output register; when the receiver stalls, a read scan holds
// until the register is taken. Reset empties all tables and sets the disk size
// to zero, so creates fail with disk undefined until the size is written.
module fat_block_allocator_unit
    import fba_pkg::*;
#(
    parameter int DISK_BLOCKS = DISK_BLOCKS_DEF,
    parameter int MAX_FILES   = MAX_FILES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_item,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam int AW = (DISK_BLOCKS > 1) ? $clog2(DISK_BLOCKS) : 1;
    localparam int FW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;

    state_t state_reg, state_next;
    file_state_t fstate_reg [MAX_FILES];
    file_state_t fstate_next [MAX_FILES];
    logic [DISK_BLOCKS-1:0] vld_reg, vld_next;

    logic [CNT_W-1:0] disk_reg, disk_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] w_reg, w_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [AW-1:0]    start_reg, start_next;
    logic             have_reg, have_next;

    in_item_t cmd_reg, cmd_next;

    logic [ST_W-1:0] rs_status_reg, rs_status_next;
    logic [AW-1:0]   rs_blk_reg, rs_blk_next;
    logic            rs_has_reg, rs_has_next;

    logic      out_vld_reg, out_vld_next;
    out_item_t out_reg, out_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr;
    logic [ID_W-1:0] ram_wdata, ram_rdata;

    logic          slot_free, valid_id, owned;
    logic [AW-1:0] i_idx;
    logic [FW-1:0] f_idx;
    file_state_t   cur_fstate;

    fba_owner_ram #(
        .DEPTH (DISK_BLOCKS),
        .AW    (AW),
        .DW    (ID_W)
    ) u_owner_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (i_idx),
        .rdata (ram_rdata)
    );

    assign slot_free  = !out_vld_reg || out_ready;
    assign i_idx      = i_reg[AW-1:0];
    assign f_idx      = cmd_reg.file_id[FW-1:0];
    assign valid_id   = (32'(cmd_reg.file_id) < MAX_FILES);
    assign cur_fstate = valid_id ? fstate_reg[f_idx] : FILE_ABSENT;
    // The owner memory holds stale data for blocks whose valid bit is clear.
    assign owned      = vld_reg[i_idx] && (ram_rdata == cmd_reg.file_id);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            vld_reg     <= '0;
            disk_reg    <= '0;
            free_reg    <= '0;
            out_vld_reg <= 1'b0;
            for (int f = 0; f < MAX_FILES; f++)
            begin
                fstate_reg[f] <= FILE_ABSENT;
            end
        end
        else
        begin
            state_reg   <= state_next;
            vld_reg     <= vld_next;
            disk_reg    <= disk_next;
            free_reg    <= free_next;
            out_vld_reg <= out_vld_next;
            fstate_reg  <= fstate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        w_reg         <= w_next;
        left_reg      <= left_next;
        start_reg     <= start_next;
        have_reg      <= have_next;
        cmd_reg       <= cmd_next;
        rs_status_reg <= rs_status_next;
        rs_blk_reg    <= rs_blk_next;
        rs_has_reg    <= rs_has_next;
        out_reg       <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        fstate_next    = fstate_reg;
        vld_next       = vld_reg;
        disk_next      = disk_reg;
        free_next      = free_reg;
        i_next         = i_reg;
        w_next         = w_reg;
        left_next      = left_reg;
        start_next     = start_reg;
        have_next      = have_reg;
        cmd_next       = cmd_reg;
        rs_status_next = rs_status_reg;
        rs_blk_next    = rs_blk_reg;
        rs_has_next    = rs_has_reg;
        out_vld_next   = out_vld_reg && !out_ready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = i_idx;
        ram_wdata      = cmd_reg.file_id;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    disk_next = (32'(cfg_data) > DISK_BLOCKS) ?
                                CNT_W'(DISK_BLOCKS) : cfg_data;
                    free_next = disk_next;
                    vld_next  = '0;
                    for (int f = 0; f < MAX_FILES; f++)
                    begin
                        fstate_next[f] = FILE_ABSENT;
                    end
                end
                if (in_valid)
                begin
                    cmd_next   = in_item;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                rs_status_next = STAT_NOFILE;
                rs_blk_next    = '0;
                rs_has_next    = 1'b0;
                i_next         = '0;
                w_next         = '0;
                state_next     = S_RESULT;
                case (cmd_reg.opcode)
                    OP_CREATE:
                    begin
                        if (disk_reg == '0)
                        begin
                            rs_status_next = STAT_UNDEF;
                        end
                        else if (!valid_id)
                        begin
                            rs_status_next = STAT_NOFILE;
                        end
                        else if (cur_fstate != FILE_ABSENT)
                        begin
                            rs_status_next = STAT_EXISTS;
                        end
                        else if (cmd_reg.block_count > free_reg)
                        begin
                            rs_status_next = STAT_NOSPACE;
                        end
                        else
                        begin
                            free_next          = free_reg - cmd_reg.block_count;
                            left_next          = cmd_reg.block_count;
                            have_next          = 1'b0;
                            start_next         = '0;
                            fstate_next[f_idx] = (cmd_reg.block_count == '0) ?
                                                 FILE_EMPTY : FILE_PRESENT;
                            state_next         = S_CREATE;
                        end
                    end
                    OP_READ:
                    begin
                        if (cur_fstate == FILE_EMPTY)
                        begin
                            rs_status_next = STAT_OK;
                        end
                        else if (cur_fstate == FILE_PRESENT)
                        begin
                            have_next  = 1'b0;
                            state_next = S_RD_REQ;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (cur_fstate != FILE_ABSENT)
                        begin
                            fstate_next[f_idx] = FILE_ABSENT;
                            state_next         = S_DEL_REQ;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_CREATE:
            begin
                if (left_reg == '0)
                begin
                    rs_status_next = STAT_OK;
                    rs_blk_next    = start_reg;
                    rs_has_next    = have_reg;
                    state_next     = S_RESULT;
                end
                else
                begin
                    // Enough free blocks were checked, so this ends before the disk does.
                    if (!vld_reg[i_idx])
                    begin
                        ram_we          = 1'b1;
                        vld_next[i_idx] = 1'b1;
                        left_next       = left_reg - 1'b1;
                        if (!have_reg)
                        begin
                            start_next = i_idx;
                            have_next  = 1'b1;
                        end
                    end
                    i_next = i_reg + 1'b1;
                end
            end

            S_RD_REQ:
            begin
                if (i_reg == disk_reg)
                begin
                    // The last block found is still held back; it closes the chain.
                    rs_status_next = STAT_OK;
                    rs_blk_next    = start_reg;
                    rs_has_next    = 1'b1;
                    state_next     = S_RESULT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_RD_CHK;
                end
            end

            S_RD_CHK:
            begin
                if (owned && have_reg)
                begin
                    if (slot_free)
                    begin
                        out_vld_next         = 1'b1;
                        out_next.status      = STAT_OK;
                        out_next.block_index = BLK_W'(start_reg);
                        out_next.has_block   = 1'b1;
                        out_next.last        = 1'b0;
                        start_next           = i_idx;
                        i_next               = i_reg + 1'b1;
                        state_next           = S_RD_REQ;
                    end
                end
                else
                begin
                    if (owned)
                    begin
                        start_next = i_idx;
                        have_next  = 1'b1;
                    end
                    i_next     = i_reg + 1'b1;
                    state_next = S_RD_REQ;
                end
            end

            S_DEL_REQ:
            begin
                if (i_reg == disk_reg)
                begin
                    state_next = S_DEL_END;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_DEL_CHK;
                end
            end

            S_DEL_CHK:
            begin
                // Surviving blocks slide down to the write pointer, order kept.
                if (vld_reg[i_idx] && (ram_rdata != cmd_reg.file_id))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = w_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    w_next    = w_reg + 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = S_DEL_REQ;
            end

            S_DEL_END:
            begin
                for (int j = 0; j < DISK_BLOCKS; j++)
                begin
                    vld_next[j] = (CNT_W'(j) < w_reg);
                end
                free_next      = disk_reg - w_reg;
                rs_status_next = STAT_OK;
                rs_blk_next    = '0;
                rs_has_next    = 1'b0;
                state_next     = S_RESULT;
            end

            S_RESULT:
            begin
                if (slot_free)
                begin
                    out_vld_next         = 1'b1;
                    out_next.status      = rs_status_reg;
                    out_next.block_index = BLK_W'(rs_blk_reg);
                    out_next.has_block   = rs_has_reg;
                    out_next.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/fba_checker.sv @@
module fba_checker
    import fba_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    // A result waiting on the receiver must not change.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result item changed while stalled");

    // Only one command is in work at a time.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");

    // Every error ends its command at once and names no block.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status != STAT_OK) |-> out_item.last && !out_item.has_block)
        else $error("error item not final or carries a block");

    // A chain item that is not the final one always names a block.
    a_mid_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.last |-> out_item.has_block && (out_item.status == STAT_OK))
        else $error("intermediate item without a block");

endmodule

bind fat_block_allocator_unit fba_checker u_fba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

@@ verif/fat_block_allocator_unit_tb.sv @@
module fat_block_allocator_unit_tb;
    import fba_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam logic [4:0] OWNER_FREE = 5'd26;
    localparam logic [6:0] LINK_END = 7'd126;
    localparam logic [6:0] LINK_FREE = 7'd127;
    localparam logic [7:0] HEAD_EMPTY = 8'd254;
    localparam logic [7:0] HEAD_ABSENT = 8'd255;
    localparam int SETTLE_CYCLES = 2 * DISK_BLOCKS_DEF + 12;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        bit        is_cfg;
        int        cfg_val;
        in_item_t  cmd;
        bit        typed;
        out_item_t want;
    } row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;
    logic      cfg_we;
    logic [CNT_W-1:0] cfg_data;

    // Allocator state as predicted by the testbench.
    logic [4:0] blk_owner [64];
    logic [6:0] blk_next [64];
    logic [7:0] file_head [32];
    int         free_blocks;
    int         disk_size;

    out_item_t  pending_results[$];
    int         error_count = 0;
    int         idle_cycles = 0;
    bit         send_gaps = 1;
    bit         recv_gaps = 1;
    bit         hold_req = 0;

    fat_block_allocator_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic void clear_disk();
        for (int i = 0; i < 64; i++)
        begin
            blk_owner[i] = OWNER_FREE;
            blk_next[i] = LINK_FREE;
        end
        for (int i = 0; i < 32; i++)
            file_head[i] = HEAD_ABSENT;
        free_blocks = disk_size;
    endfunction

    function automatic void set_disk_size(int v);
        disk_size = (v > DISK_BLOCKS_DEF) ? DISK_BLOCKS_DEF : v;
        clear_disk();
    endfunction

    function automatic void push_result(logic [ST_W-1:0] st, int blk, bit has, bit fin);
        out_item_t r;
        r.status = st;
        r.block_index = blk[BLK_W-1:0];
        r.has_block = has;
        r.last = fin;
        pending_results.push_back(r);
    endfunction

    // Pack used blocks to the front in disk order and rebuild every chain.
    function automatic void compact_disk();
        logic [4:0] packed_owner [64];
        int used;
        used = 0;
        for (int i = 0; i < 64; i++)
            packed_owner[i] = OWNER_FREE;
        for (int i = 0; i < disk_size; i++)
            if (blk_owner[i] != OWNER_FREE)
            begin
                packed_owner[used] = blk_owner[i];
                used++;
            end
        for (int f = 0; f < MAX_FILES_DEF; f++)
            if (file_head[f] != HEAD_ABSENT && file_head[f] != HEAD_EMPTY)
                file_head[f] = HEAD_ABSENT;
        for (int i = 0; i < 64; i++)
        begin
            blk_owner[i] = packed_owner[i];
            blk_next[i] = LINK_FREE;
        end
        for (int i = 0; i < used; i++)
        begin
            blk_next[i] = LINK_END;
            if (i > 0 && packed_owner[i] == packed_owner[i-1])
                blk_next[i-1] = i[6:0];
            else if (file_head[packed_owner[i]] == HEAD_ABSENT)
                file_head[packed_owner[i]] = i[7:0];
        end
        free_blocks = disk_size - used;
    endfunction

    function automatic void predict_command(in_item_t c);
        int id;
        int cnt;
        int left;
        int first;
        int prev;
        int pos;
        int k;
        bit found;
        bit fin;
        id = c.file_id;
        cnt = c.block_count;
        case (c.opcode)
            OP_CREATE:
            begin
                if (disk_size == 0)
                    push_result(STAT_UNDEF, 0, 0, 1);
                else if (id >= MAX_FILES_DEF)
                    push_result(STAT_NOFILE, 0, 0, 1);
                else if (file_head[id] != HEAD_ABSENT)
                    push_result(STAT_EXISTS, 0, 0, 1);
                else if (cnt > free_blocks)
                    push_result(STAT_NOSPACE, 0, 0, 1);
                else
                begin
                    left = cnt;
                    first = 0;
                    prev = 0;
                    found = 0;
                    for (int i = 0; i < disk_size && left > 0; i++)
                        if (blk_owner[i] == OWNER_FREE)
                        begin
                            blk_owner[i] = id[4:0];
                            if (!found)
                            begin
                                first = i;
                                found = 1;
                            end
                            else
                                blk_next[prev] = i[6:0];
                            blk_next[i] = LINK_END;
                            prev = i;
                            left--;
                        end
                    free_blocks -= cnt;
                    file_head[id] = found ? first[7:0] : HEAD_EMPTY;
                    push_result(STAT_OK, first, found, 1);
                end
            end
            OP_READ:
            begin
                if (id >= MAX_FILES_DEF || file_head[id] == HEAD_ABSENT)
                    push_result(STAT_NOFILE, 0, 0, 1);
                else if (file_head[id] == HEAD_EMPTY)
                    push_result(STAT_OK, 0, 0, 1);
                else
                begin
                    pos = file_head[id] & 63;
                    k = 0;
                    fin = 0;
                    while (!fin)
                    begin
                        fin = (blk_next[pos] >= disk_size) || (k + 1 >= DISK_BLOCKS_DEF);
                        push_result(STAT_OK, pos, 1, fin);
                        k++;
                        pos = blk_next[pos] & 63;
                    end
                end
            end
            OP_DELETE:
            begin
                if (id >= MAX_FILES_DEF || file_head[id] == HEAD_ABSENT)
                    push_result(STAT_NOFILE, 0, 0, 1);
                else
                begin
                    for (int i = 0; i < 64; i++)
                        if (blk_owner[i] == id[4:0])
                        begin
                            blk_owner[i] = OWNER_FREE;
                            blk_next[i] = LINK_FREE;
                        end
                    file_head[id] = HEAD_ABSENT;
                    compact_disk();
                    push_result(STAT_OK, 0, 0, 1);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic in_item_t make_cmd(logic [OP_W-1:0] op, int id, int cnt);
        in_item_t c;
        c.opcode = op;
        c.file_id = id[ID_W-1:0];
        c.block_count = cnt[CNT_W-1:0];
        return c;
    endfunction

    function automatic row_t cmd_row(logic [OP_W-1:0] op, int id, int cnt);
        row_t r;
        r.is_cfg = 0;
        r.cfg_val = 0;
        r.cmd = make_cmd(op, id, cnt);
        r.typed = 0;
        r.want = '0;
        return r;
    endfunction

    function automatic row_t typed_row(logic [OP_W-1:0] op, int id, int cnt,
                                       logic [ST_W-1:0] st, int blk, bit has);
        row_t r;
        r = cmd_row(op, id, cnt);
        r.typed = 1;
        r.want.status = st;
        r.want.block_index = blk[BLK_W-1:0];
        r.want.has_block = has;
        r.want.last = 1'b1;
        return r;
    endfunction

    function automatic row_t cfg_row(int v);
        row_t r;
        r = cmd_row(OP_NONE, 0, 0);
        r.is_cfg = 1;
        r.cfg_val = v;
        return r;
    endfunction

    task automatic send_command(in_item_t c, bit typed, out_item_t want);
        int gap;
        gap = send_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= c;
        do
            @(posedge clk);
        while (!in_ready);
        predict_command(c);
        if (typed)
        begin
            void'(pending_results.pop_back());
            pending_results.push_back(want);
        end
    endtask

    // The disk size is only written once the block has drained and settled.
    task automatic write_disk_size(int v);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v[CNT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        set_disk_size(v);
    endtask

    function automatic in_item_t random_command();
        int r;
        int id;
        int cnt;
        r = $urandom_range(0, 99);
        id = $urandom_range(0, MAX_FILES_DEF - 1);
        cnt = $urandom_range(0, disk_size / 3 + 1);
        if ($urandom_range(0, 19) == 0)
            cnt = $urandom_range(64, 127);
        if (r < 42)
            return make_cmd(OP_CREATE, id, cnt);
        else if (r < 66)
            return make_cmd(OP_READ, id, $urandom_range(0, 127));
        else if (r < 86)
            return make_cmd(OP_DELETE, id, $urandom_range(0, 127));
        else if (r < 94)
            return make_cmd(OP_W'($urandom_range(0, 2)), $urandom_range(16, 31), cnt);
        else
            return make_cmd(OP_NONE, $urandom_range(0, 31), $urandom_range(0, 127));
    endfunction

    initial
    begin
        row_t rows[$];
        int phase_size[5];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        set_disk_size(0);

        rows.push_back(typed_row(OP_CREATE, 0, 3, STAT_UNDEF, 0, 0));
        rows.push_back(typed_row(OP_READ, 0, 0, STAT_NOFILE, 0, 0));
        rows.push_back(typed_row(OP_DELETE, 0, 0, STAT_NOFILE, 0, 0));
        rows.push_back(cmd_row(OP_NONE, 31, 127));
        rows.push_back(cfg_row(64));
        rows.push_back(typed_row(OP_CREATE, 31, 1, STAT_NOFILE, 0, 0));
        rows.push_back(typed_row(OP_CREATE, 0, 0, STAT_OK, 0, 0));
        rows.push_back(typed_row(OP_CREATE, 0, 1, STAT_EXISTS, 0, 0));
        rows.push_back(typed_row(OP_CREATE, 1, 127, STAT_NOSPACE, 0, 0));
        rows.push_back(typed_row(OP_CREATE, 1, 64, STAT_OK, 0, 1));
        rows.push_back(cmd_row(OP_READ, 1, 0));
        rows.push_back(typed_row(OP_CREATE, 2, 1, STAT_NOSPACE, 0, 0));
        rows.push_back(typed_row(OP_READ, 0, 0, STAT_OK, 0, 0));
        rows.push_back(cmd_row(OP_DELETE, 1, 0));
        rows.push_back(cmd_row(OP_CREATE, 2, 5));
        rows.push_back(cmd_row(OP_CREATE, 3, 3));
        rows.push_back(cmd_row(OP_CREATE, 4, 2));
        rows.push_back(cmd_row(OP_DELETE, 3, 0));
        rows.push_back(cmd_row(OP_READ, 4, 0));
        rows.push_back(cmd_row(OP_READ, 2, 0));
        rows.push_back(typed_row(OP_DELETE, 25, 0, STAT_NOFILE, 0, 0));
        rows.push_back(typed_row(OP_READ, 31, 0, STAT_NOFILE, 0, 0));
        rows.push_back(cfg_row(127));
        rows.push_back(typed_row(OP_CREATE, 25, 64, STAT_OK, 0, 1));
        rows.push_back(cfg_row(0));
        rows.push_back(typed_row(OP_CREATE, 2, 0, STAT_UNDEF, 0, 0));
        rows.push_back(cfg_row(1));
        rows.push_back(typed_row(OP_CREATE, 1, 1, STAT_OK, 0, 1));
        rows.push_back(typed_row(OP_CREATE, 2, 1, STAT_NOSPACE, 0, 0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                write_disk_size(rows[i].cfg_val);
            else
                send_command(rows[i].cmd, rows[i].typed, rows[i].want);
        end

        phase_size = '{64, 127, 1, 8, 0};
        phase_size[4] = $urandom_range(2, 63);
        for (int p = 0; p < 5; p++)
        begin
            write_disk_size(phase_size[p]);
            send_gaps = (p != 2);
            recv_gaps = (p != 3);
            if (p == 1)
                hold_req = 1;
            for (int n = 0; n < 21; n++)
                send_command(random_command(), 0, '0);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off so the input backs up.
    initial
    begin
        int wait_n;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                wait_n = HOLD_CYCLES;
                hold_req = 0;
            end
            else
                wait_n = recv_gaps ? $urandom_range(0, 9) : 0;
            if (wait_n > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_item.status);
                    error_count++;
                end
                if (out_item.block_index !== want.block_index)
                begin
                    $display("%0t: block_index expected %0d actual %0d",
                             $time, want.block_index, out_item.block_index);
                    error_count++;
                end
                if (out_item.has_block !== want.has_block)
                begin
                    $display("%0t: has_block expected %0d actual %0d",
                             $time, want.has_block, out_item.has_block);
                    error_count++;
                end
                if (out_item.last !== want.last)
                begin
                    $display("%0t: last expected %0d actual %0d",
                             $time, want.last, out_item.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
